/* hdl/pcc_pkg.sv */
// Shared types and constants of the polar/cartesian converter.
// Holds beat structs, the datapath bus between pipeline cells and the arctangent table.
// Depends on nothing; every other file of the block refers to it by scoped names.
package pcc_pkg;

    localparam int COORD_WIDTH        = 16;
    localparam int GUARD_BITS         = 4;
    localparam int ITERATIONS_DEFAULT = 16;
    localparam int ATAN_LEN           = 24;
    // Datapath width: operand, prescale growth, guard bits and CORDIC growth.
    localparam int DATA_WIDTH         = COORD_WIDTH + GUARD_BITS + 3;
    localparam int ANGLE_WIDTH        = 32;

    // 0.60725293500888 in Q0.31.
    localparam logic signed [31:0] GAIN_COMP = 32'sd1304065748;

    localparam logic [ANGLE_WIDTH-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef enum logic {
        ACT_TO_POLAR = 1'b0,
        ACT_TO_RECT  = 1'b1
    } t_action;

    typedef struct packed {
        logic                          action;
        logic signed [COORD_WIDTH-1:0] in_first;
        logic signed [COORD_WIDTH-1:0] in_second;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_WIDTH:0]   out_first;
        logic signed [COORD_WIDTH-1:0] out_second;
    } t_out_beat;

    // Working vector handed from cell to cell.
    typedef struct packed {
        logic                         rot;   // rotation mode (polar to rectangular)
        logic                         zero;  // zero vector in vectoring mode
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic [ANGLE_WIDTH-1:0]       z;
    } t_cell_data;

endpackage

/* hdl/pcc_pre.sv */
// Front end of the converter pipeline: quadrant folding and gain-compensating prescale.
// Two register stages; uses pcc_pkg for beat and bus types.
module pcc_pre (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  pcc_pkg::t_in_beat   i_data,
    output logic                o_valid,
    output pcc_pkg::t_cell_data o_data
);

    localparam int W   = pcc_pkg::COORD_WIDTH;
    localparam int VW  = W + 1;
    localparam int PW  = VW + 32;
    localparam int DW  = pcc_pkg::DATA_WIDTH;
    localparam int AW  = pcc_pkg::ANGLE_WIDTH;
    localparam int G   = pcc_pkg::GUARD_BITS;
    localparam logic signed [PW-1:0] PRESCALE_RND = PW'(64'sd1 <<< (30 - G));
    localparam logic [AW-1:0] ANGLE_PI = AW'(64'd1 << (AW - 1));

    logic signed [VW-1:0] a_ext;
    logic signed [VW-1:0] b_ext;
    logic [AW-1:0]        z_rot;
    logic                 n_rot;
    logic                 n_zero;
    logic signed [VW-1:0] n_x;
    logic signed [VW-1:0] n_y;
    logic [AW-1:0]        n_z;

    logic                 r_a_valid;
    logic                 r_a_rot;
    logic                 r_a_zero;
    logic signed [VW-1:0] r_a_x;
    logic signed [VW-1:0] r_a_y;
    logic [AW-1:0]        r_a_z;

    logic signed [PW-1:0] prod_x;
    logic signed [PW-1:0] prod_y;
    logic signed [PW-1:0] scl_x;
    logic signed [PW-1:0] scl_y;

    logic                 r_valid;
    pcc_pkg::t_cell_data  r_data;

    assign a_ext = VW'(i_data.in_first);
    assign b_ext = VW'(i_data.in_second);
    assign z_rot = AW'($unsigned(i_data.in_second)) << (AW - W);

    always_comb begin
        n_rot  = (i_data.action == pcc_pkg::ACT_TO_RECT);
        n_zero = 1'b0;
        n_x    = a_ext;
        n_y    = b_ext;
        n_z    = '0;
        if (n_rot) begin
            // Rotation starts from (r, 0); back quadrants take pi off and flip the radius.
            n_y = '0;
            n_z = z_rot;
            if (z_rot[AW-1] ^ z_rot[AW-2]) begin
                n_z = z_rot ^ ANGLE_PI;
                n_x = -a_ext;
            end
        end else begin
            n_zero = (a_ext == '0) && (b_ext == '0);
            // Left half plane is mirrored through the origin and starts at pi.
            if (a_ext[VW-1]) begin
                n_x = -a_ext;
                n_y = -b_ext;
                n_z = ANGLE_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_rot  <= n_rot;
            r_a_zero <= n_zero;
            r_a_x    <= n_x;
            r_a_y    <= n_y;
            r_a_z    <= n_z;
        end
    end

    assign prod_x = r_a_x * pcc_pkg::GAIN_COMP;
    assign prod_y = r_a_y * pcc_pkg::GAIN_COMP;
    assign scl_x  = (prod_x + PRESCALE_RND) >>> (31 - G);
    assign scl_y  = (prod_y + PRESCALE_RND) >>> (31 - G);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data.rot  <= r_a_rot;
            r_data.zero <= r_a_zero;
            r_data.x    <= scl_x[DW-1:0];
            r_data.y    <= scl_y[DW-1:0];
            r_data.z    <= r_a_z;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // A folded rotation angle always lies in [-pi/2, pi/2).
    a_rot_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.rot) |-> (r_data.z[AW-1] == r_data.z[AW-2]))
        else $error("rotation angle not folded into the front half plane");

endmodule

/* hdl/pcc_cell.sv */
// One CORDIC micro-rotation stage with its output register.
// Shift amount and arctangent come from STAGE; uses pcc_pkg for the bus type and table.
module pcc_cell #(
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  pcc_pkg::t_cell_data i_data,
    output logic                o_valid,
    output pcc_pkg::t_cell_data o_data
);

    localparam int DW = pcc_pkg::DATA_WIDTH;
    localparam logic [pcc_pkg::ANGLE_WIDTH-1:0] ATAN = pcc_pkg::ATAN_TAB[STAGE];

    logic                 ccw;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    pcc_pkg::t_cell_data  n_data;
    logic                 r_valid;
    pcc_pkg::t_cell_data  r_data;

    // Rotation drives the residual angle to zero, vectoring drives y to zero.
    assign ccw = i_data.rot ? !i_data.z[pcc_pkg::ANGLE_WIDTH-1] : i_data.y[DW-1];
    assign dx  = i_data.y >>> STAGE;
    assign dy  = i_data.x >>> STAGE;

    always_comb begin
        n_data = i_data;
        if (ccw) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ATAN;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hdl/pcc_post.sv */
// Back end of the converter pipeline: rounding, saturation, angle reduction, output register.
// Uses pcc_pkg for the bus and result beat types.
module pcc_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  pcc_pkg::t_cell_data i_data,
    output logic                o_valid,
    output pcc_pkg::t_out_beat  o_data
);

    localparam int W  = pcc_pkg::COORD_WIDTH;
    localparam int DW = pcc_pkg::DATA_WIDTH;
    localparam int AW = pcc_pkg::ANGLE_WIDTH;
    localparam int G  = pcc_pkg::GUARD_BITS;
    localparam int ANGLE_SHIFT = AW - W;
    localparam logic signed [DW-1:0] OUT_RND = DW'(64'sd1 <<< (G - 1));
    localparam logic signed [DW-1:0] ROT_HI  = DW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] ROT_LO  = DW'(-(64'sd1 <<< (W - 1)));
    localparam logic signed [DW-1:0] MAG_HI  = DW'((64'sd1 <<< W) - 64'sd1);
    localparam logic signed [DW-1:0] MAG_LO  = '0;

    logic signed [DW-1:0] x_rnd;
    logic signed [DW-1:0] y_rnd;
    logic signed [DW-1:0] x_sat;
    logic signed [DW-1:0] y_sat;
    logic [W-1:0]         angle;
    pcc_pkg::t_out_beat   n_data;
    logic                 r_valid;
    pcc_pkg::t_out_beat   r_data;

    assign x_rnd = (i_data.x + OUT_RND) >>> G;
    assign y_rnd = (i_data.y + OUT_RND) >>> G;

    generate
        if (ANGLE_SHIFT > 0) begin : g_angle_round
            assign angle = i_data.z[AW-1:ANGLE_SHIFT] + W'(i_data.z[ANGLE_SHIFT-1]);
        end else begin : g_angle_full
            assign angle = i_data.z[W-1:0];
        end
    endgenerate

    always_comb begin
        if (i_data.rot) begin
            x_sat = (x_rnd > ROT_HI) ? ROT_HI : ((x_rnd < ROT_LO) ? ROT_LO : x_rnd);
        end else begin
            x_sat = (x_rnd > MAG_HI) ? MAG_HI : ((x_rnd < MAG_LO) ? MAG_LO : x_rnd);
        end
        y_sat = (y_rnd > ROT_HI) ? ROT_HI : ((y_rnd < ROT_LO) ? ROT_LO : y_rnd);

        if (i_data.rot) begin
            n_data.out_first  = x_sat[W:0];
            n_data.out_second = y_sat[W-1:0];
        end else if (i_data.zero) begin
            n_data.out_first  = '0;
            n_data.out_second = '0;
        end else begin
            n_data.out_first  = x_sat[W:0];
            n_data.out_second = angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hdl/polar_cartesian_converter_core.sv */
// Top level of the polar/cartesian converter: input skid buffer and the CORDIC pipeline.
// Instantiates pcc_pre, pcc_cell (ITERATIONS times) and pcc_post; uses pcc_pkg.
//
// This block converts a 2-D vector between rectangular and polar form with a fully
// pipelined CORDIC. Action 0 takes (x, y) in Q2.14 and returns the magnitude (17 bits,
// Q3.14, held between 0 and the top of the signed range) and the angle atan2(y, x) as a
// 16-bit binary angle where -32768 stands for -pi; an angle of exactly pi comes out as
// -32768 and the zero vector gives zero for both results. Action 1 takes a radius and a
// binary angle and returns r*cos(phi) and r*sin(phi), saturated to 16 bits. The block
// accepts one beat per clock while the pipeline is not frozen and returns one result
// beat per input beat, in order. Each beat passes through two front-end stages (quadrant
// folding, then the gain-compensating multiply), one register per micro-rotation cell,
// and the output register. When the consumer holds i_ready low while a result waits, the
// whole pipeline freezes and a one-beat skid buffer at the input absorbs the beat already
// offered, so o_ready depends only on registers and never combinationally on i_ready.

module polar_cartesian_converter_core #(
    parameter int ITERATIONS = pcc_pkg::ITERATIONS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pcc_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pcc_pkg::t_out_beat o_data
);

    // The whole pipeline advances together unless a finished result is being held.
    logic pipe_en;

    // Skid buffer that parks one beat while the pipeline is frozen.
    logic              r_skid_valid;
    pcc_pkg::t_in_beat r_skid;

    logic              src_valid;
    pcc_pkg::t_in_beat src_data;

    logic                chain_valid [ITERATIONS+1];
    pcc_pkg::t_cell_data chain_data  [ITERATIONS+1];

    assign pipe_en  = !o_valid || i_ready;
    assign o_ready  = !r_skid_valid;

    // While the skid holds a beat, o_ready is low, so the skid is the only source.
    assign src_valid = r_skid_valid || i_valid;
    assign src_data  = r_skid_valid ? r_skid : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (pipe_en) begin
            r_skid_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!pipe_en && i_valid && o_ready) begin
            r_skid <= i_data;
        end
    end

    pcc_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (src_valid),
        .i_data  (src_data),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0])
    );

    // One cell per micro-rotation; each hands its vector to the next every cycle the pipeline advances.
    generate
        for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
            pcc_cell #(
                .STAGE (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (pipe_en),
                .i_valid (chain_valid[k]),
                .i_data  (chain_data[k]),
                .o_valid (chain_valid[k+1]),
                .o_data  (chain_data[k+1])
            );
        end
    endgenerate

    pcc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (chain_valid[ITERATIONS]),
        .i_data  (chain_data[ITERATIONS]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // The skid is only ever filled while the pipeline is frozen.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> $past(!pipe_en))
        else $error("skid buffer holds a beat that the pipeline could have taken");

    // Once the pipeline moves, the parked beat is drained at that edge.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pipe_en) |=> !r_skid_valid)
        else $error("skid buffer not drained when the pipeline advanced");

    // A beat accepted during a freeze must be parked, not dropped.
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !pipe_en) |=> r_skid_valid)
        else $error("beat accepted during a stall was lost");

endmodule

/* test/pcc_result_checker.sv */
// Result checker for the polar/cartesian converter: predicts every result beat and compares.
// Watches both channels of polar_cartesian_converter_core; uses types and tables of pcc_pkg.
module pcc_result_checker #(
    parameter int ITERATIONS = pcc_pkg::ITERATIONS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  pcc_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pcc_pkg::t_out_beat i_out_beat,
    output int                 o_mismatch_count,
    output int                 o_outstanding
);

    localparam int W = pcc_pkg::COORD_WIDTH;
    localparam int G = pcc_pkg::GUARD_BITS;

    pcc_pkg::t_out_beat pending_conversions[$];
    pcc_pkg::t_out_beat wanted;

    function automatic longint gain_scale(longint v);
        return (v * longint'(pcc_pkg::GAIN_COMP) + (longint'(1) << (30 - G)))
               >>> (31 - G);
    endfunction

    function automatic longint drop_guard(longint v);
        return (v + (longint'(1) << (G - 1))) >>> G;
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic pcc_pkg::t_out_beat convert_beat(pcc_pkg::t_in_beat beat);
        pcc_pkg::t_out_beat res;
        longint      a;
        longint      b;
        longint      x;
        longint      y;
        longint      zs;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        logic [31:0] probe;
        logic [32:0] rounded_angle;
        res = '0;
        a = longint'($signed(beat.in_first));
        b = longint'($signed(beat.in_second));
        if (beat.action == pcc_pkg::ACT_TO_POLAR) begin
            if (a != 0 || b != 0) begin
                z = '0;
                // Vectors in the left half plane are mirrored and start at pi.
                if (a < 0) begin
                    a = -a;
                    b = -b;
                    z = 32'h8000_0000;
                end
                x = gain_scale(a);
                y = gain_scale(b);
                for (int i = 0; i < ITERATIONS && i < pcc_pkg::ATAN_LEN; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0) begin
                        x += dx;
                        y -= dy;
                        z += pcc_pkg::ATAN_TAB[i];
                    end else begin
                        x -= dx;
                        y += dy;
                        z -= pcc_pkg::ATAN_TAB[i];
                    end
                end
                res.out_first = (W+1)'(saturate(drop_guard(x), 0, (longint'(1) << W) - 1));
                // Round half up to W bits; a carry out of the top wraps pi to -pi.
                rounded_angle = {1'b0, z} + (33'd1 << (31 - W));
                res.out_second = rounded_angle[31 -: W];
            end
        end else begin
            z = 32'($unsigned(beat.in_second)) << (32 - W);
            probe = z + 32'h4000_0000;
            // Angles in the back quadrants take pi off and negate the radius.
            if (probe[31]) begin
                z += 32'h8000_0000;
                a = -a;
            end
            zs = longint'($signed(z));
            x = gain_scale(a);
            y = 0;
            for (int i = 0; i < ITERATIONS && i < pcc_pkg::ATAN_LEN; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (zs >= 0) begin
                    x -= dx;
                    y += dy;
                    zs -= longint'(pcc_pkg::ATAN_TAB[i]);
                end else begin
                    x += dx;
                    y -= dy;
                    zs += longint'(pcc_pkg::ATAN_TAB[i]);
                end
            end
            res.out_first = (W+1)'(saturate(drop_guard(x), -(longint'(1) << (W - 1)),
                                            (longint'(1) << (W - 1)) - 1));
            res.out_second = W'(saturate(drop_guard(y), -(longint'(1) << (W - 1)),
                                         (longint'(1) << (W - 1)) - 1));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_mismatch_count++;
    endtask

    // Results are compared before the input beat of the same edge is queued, since a
    // beat accepted now cannot already be at the output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (pending_conversions.size() == 0) begin
                    report_mismatch($sformatf("result beat (%0d, %0d) with nothing outstanding",
                                              i_out_beat.out_first, i_out_beat.out_second));
                end else begin
                    wanted = pending_conversions.pop_front();
                    if (i_out_beat.out_first !== wanted.out_first) begin
                        report_mismatch($sformatf("out_first got %0d expected %0d",
                                                  i_out_beat.out_first, wanted.out_first));
                    end
                    if (i_out_beat.out_second !== wanted.out_second) begin
                        report_mismatch($sformatf("out_second got %0d expected %0d",
                                                  i_out_beat.out_second, wanted.out_second));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_conversions.push_back(convert_beat(i_in_beat));
            end
            o_outstanding = pending_conversions.size();
        end
    end

endmodule

/* test/tb_polar_cartesian_converter_core.sv */
// Testbench top for polar_cartesian_converter_core: clock, reset, stimulus and verdict.
// Depends on pcc_pkg, the block itself and pcc_result_checker, which predicts and compares.
module tb_polar_cartesian_converter_core;

    localparam int W            = pcc_pkg::COORD_WIDTH;
    localparam int ITERATIONS   = pcc_pkg::ITERATIONS_DEFAULT;
    // Two front-end stages, one register per micro-rotation and the output register.
    localparam int LATENCY      = ITERATIONS + 3;
    localparam int RANDOM_BEATS = 600;
    // Beats in the window where the sender never idles and the receiver holds off.
    localparam int FLOOD_FIRST  = 200;
    localparam int FLOOD_LAST   = 300;
    localparam int FLOOD_HOLD   = 300;
    // Watchdog limit, well above the length of the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [W-1:0] MOST_NEG     = {1'b1, {(W - 1){1'b0}}};
    localparam logic signed [W-1:0] MOST_POS     = {1'b0, {(W - 1){1'b1}}};
    // Binary angles: a half turn is the most negative code, standing for pi.
    localparam logic signed [W-1:0] QUARTER_TURN = W'(1) << (W - 2);
    localparam logic signed [W-1:0] EIGHTH_TURN  = W'(1) << (W - 3);

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    pcc_pkg::t_in_beat  i_data;
    logic               o_valid;
    logic               i_ready;
    pcc_pkg::t_out_beat o_data;

    int mismatch_count;
    int outstanding;
    int cycle_count;
    // Raised by the sender when its flood window starts; the receiver then holds off.
    bit flood_phase = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    polar_cartesian_converter_core #(
        .ITERATIONS(ITERATIONS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    pcc_result_checker #(
        .ITERATIONS(ITERATIONS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_beat       (i_data),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_beat      (o_data),
        .o_mismatch_count(mismatch_count),
        .o_outstanding   (outstanding)
    );

    // Idle stretches are mostly zero or a few cycles, with an occasional long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 80);
    endfunction

    // Operands are mostly uniform over the full range, so every bit toggles, with a
    // share of extremes and of small values near the origin.
    function automatic logic signed [W-1:0] random_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 4))
                0: return MOST_NEG;
                1: return MOST_POS;
                2: return '0;
                3: return W'(1);
                default: return '1;
            endcase
        end else if (r < 3) begin
            return W'($urandom_range(0, 64)) - W'(32);
        end
        return W'($urandom);
    endfunction

    // Offers one beat after an optional idle gap and returns at the edge that takes it.
    // Valid stays high between back-to-back beats, so it gets one assignment per edge.
    task automatic send_beat(input pcc_pkg::t_action act, input logic signed [W-1:0] first,
                             input logic signed [W-1:0] second, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{action: act, in_first: first, in_second: second};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Sender: reset, a directed set of corner cases, then random beats in chunks that
    // either idle at random or run back to back.
    initial begin : producer
        bit steady;
        steady = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The zero vector, the axes, the corners and vectors on the negative x axis,
        // whose angle rounds to pi and wraps to the most negative code.
        send_beat(pcc_pkg::ACT_TO_POLAR, '0, '0, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, MOST_POS, '0, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, MOST_NEG, '0, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, -W'(1), '0, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, '0, MOST_POS, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, '0, MOST_NEG, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, MOST_POS, MOST_POS, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, MOST_NEG, MOST_NEG, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, MOST_NEG, MOST_POS, idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, MOST_NEG, W'(1), idle_length());
        send_beat(pcc_pkg::ACT_TO_POLAR, W'(1), -W'(1), idle_length());
        // Rotation at the quadrant boundaries, where the back quadrants are folded,
        // with radii that saturate the outputs.
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, '0, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_NEG, '0, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, QUARTER_TURN, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, QUARTER_TURN - W'(1), idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, MOST_NEG, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_NEG, MOST_NEG, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, -QUARTER_TURN, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, -QUARTER_TURN - W'(1), idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_POS, MOST_POS, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, '0, EIGHTH_TURN, idle_length());
        send_beat(pcc_pkg::ACT_TO_RECT, MOST_NEG, EIGHTH_TURN, idle_length());

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            if (n == FLOOD_FIRST) begin
                flood_phase = 1'b1;
            end
            send_beat(pcc_pkg::t_action'($urandom_range(0, 1)), random_coord(),
                      random_coord(),
                      (steady || (n >= FLOOD_FIRST && n < FLOOD_LAST)) ? 0 : idle_length());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        // Drain: every queued prediction must come back, then a quiet tail catches
        // any stray result beat.
        wait (outstanding == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver: ready drops for random stretches, with steady periods in between, and
    // once holds off for a long stretch while the sender floods, so that the pipeline
    // fills up and the block stalls its input.
    initial begin : consumer
        int stall_left;
        bit steady;
        bit flood_seen;
        stall_left = 0;
        steady     = 1'b0;
        flood_seen = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (flood_phase && !flood_seen) begin
                flood_seen = 1'b1;
                stall_left = FLOOD_HOLD;
            end
            if ($urandom_range(0, 149) == 0) begin
                steady = !steady;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (!steady && $urandom_range(0, 2) == 0) begin
                    stall_left = idle_length();
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
